@@ hdl/sws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_pkg: shared types and constants for the sliding window statistics core
// window geometry, percentile constants, the divider request struct and the ram request struct
// ----------------------------------------------------------------------------
package sws_pkg;
	localparam int Window   = 256;
	localparam int Channels = 16;
	localparam int PtrW     = $clog2(Window);
	localparam int CntW     = $clog2(Window + 1);
	localparam int ChW      = $clog2(Channels);
	localparam int AddrW    = ChW + PtrW;
	localparam int DataW    = 32;
	localparam int SumW     = DataW + PtrW;
	localparam int BpW      = 14;
	localparam logic [BpW-1:0] BpFull  = BpW'(10000);
	localparam logic [BpW-1:0] BpReset = BpW'(5000);

	typedef struct packed {
		logic             we;
		logic [AddrW-1:0] waddr;
		logic [AddrW-1:0] raddr;
		logic [DataW-1:0] wdata;
	} ram_req_t;

	typedef struct packed {
		logic             start;
		logic [SumW-1:0]  dividend;
		logic [CntW-1:0]  divisor;
	} div_req_t;
endpackage

@@ hdl/sws_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_ram: generic simple dual port ram
// one write and one read per cycle, registered read data
// ----------------------------------------------------------------------------
module sws_ram #(
	parameter int Width = 32,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [$clog2(Depth)-1:0] raddr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ hdl/sws_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sws_div: serial signed divider
// restoring divide, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module sws_div
	import sws_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  div_req_t                req,
	output logic                    done,
	output logic signed [DataW-1:0] quot
);
	localparam int StepW = $clog2(SumW + 1);

	logic [SumW-1:0]  num_q;
	logic [SumW:0]    rem_q;
	logic [CntW-1:0]  den_q;
	logic             neg_q;
	logic             busy_q;
	logic [StepW-1:0] step_q;
	logic [SumW:0]    shifted;
	logic [SumW:0]    diff;
	logic [SumW-1:0]  mag;
	logic [SumW-1:0]  res;

	assign mag     = req.dividend[SumW-1] ? (~req.dividend + SumW'(1)) : req.dividend;
	assign shifted = {rem_q[SumW-1:0], num_q[SumW-1]};
	assign diff    = shifted - {{(SumW + 1 - CntW){1'b0}}, den_q};
	assign res     = neg_q ? (~num_q + SumW'(1)) : num_q;
	assign quot    = res[DataW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= StepW'(SumW);
			end else if (busy_q) begin
				step_q <= step_q - StepW'(1);
				if (step_q == StepW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= mag;
			rem_q <= '0;
			den_q <= req.divisor;
			neg_q <= req.dividend[SumW-1];
		end else if (busy_q) begin
			if (!diff[SumW]) begin
				rem_q <= diff;
				num_q <= {num_q[SumW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				num_q <= {num_q[SumW-2:0], 1'b0};
			end
		end
	end
endmodule

@@ hdl/sliding_window_stats_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_stats_core: per channel window min, max, mean, percentile
//
// input channel: valid/ready with channel and Q16.16 sample; the sample is
// appended to that channel's window of the last 256 samples, the oldest one
// dropped once the window is full. the window is kept as a ring and as a
// sorted list in two simple dual port rams, one word read and one written
// per cycle.
// output channel: valid/ready with count, mean, minimum, maximum and the
// order statistic at floor(min(bp,10000)*(count-1)/10000).
// cfg channel: valid/ready write of percentile_bp, only while idle.
// per item the sorted list is walked once to remove the old sample when
// the window is full, once to insert the new one, then read at three
// places; the serial divider for the mean runs alongside and sets the
// pace while the window is short. a stalled receiver holds the block.
// the block takes one item at a time; in_ready is low while busy and
// while a result waits on a stalled receiver.
// reset clears counts, pointers and sums; ram contents need no clearing.
// ----------------------------------------------------------------------------
module sliding_window_stats_core
	import sws_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [BpW-1:0]          percentile_bp,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [3:0]              channel,
	input  logic signed [DataW-1:0] sample,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CntW-1:0]         count,
	output logic signed [DataW-1:0] mean,
	output logic signed [DataW-1:0] minimum,
	output logic signed [DataW-1:0] maximum,
	output logic signed [DataW-1:0] percentile_value
);
	localparam logic [3:0] StIdle  = 4'd0;
	localparam logic [3:0] StOld   = 4'd1;
	localparam logic [3:0] StOldW  = 4'd2;
	localparam logic [3:0] StRem   = 4'd3;
	localparam logic [3:0] StIns   = 4'd4;
	localparam logic [3:0] StDiv   = 4'd5;
	localparam logic [3:0] StRdMin = 4'd6;
	localparam logic [3:0] StRdMax = 4'd7;
	localparam logic [3:0] StRdPct = 4'd8;
	localparam logic [3:0] StWait  = 4'd9;
	localparam logic [3:0] StOut   = 4'd10;

	// floor(p/10000) as (p*ceil(2^36/10000)) >> 36, exact for p below 2^23
	localparam int                RecipW  = 23;
	localparam int                RecipSh = 36;
	localparam logic [RecipW-1:0] BpRecip = RecipW'(6871948);

	logic [3:0]              state_q;
	logic [BpW-1:0]          bp_q;
	logic [PtrW-1:0]         wp_q  [Channels];
	logic [CntW-1:0]         cnt_q [Channels];
	logic signed [SumW-1:0]  sum_q [Channels];
	logic [ChW-1:0]          ch_q;
	logic signed [DataW-1:0] x_q;
	logic signed [DataW-1:0] old_q;
	logic signed [DataW-1:0] carry_q;
	logic [CntW-1:0]         n_q;
	logic [CntW-1:0]         i_q;
	logic                    found_q;
	logic                    placed_q;
	logic                    rd_pend_q;
	logic [PtrW-1:0]         idx_q;
	logic                    div_done_q;
	logic signed [DataW-1:0] min_q;
	logic signed [DataW-1:0] max_q;
	logic [BpW+CntW-1:0]     prod_q;

	ram_req_t                ring_req;
	ram_req_t                sort_req;
	logic [DataW-1:0]        ring_rd;
	logic signed [DataW-1:0] sort_rd;
	div_req_t                div_req;
	logic                    div_done;
	logic signed [DataW-1:0] div_q;
	logic [BpW-1:0]          bp_sat;
	logic [BpW+CntW-1:0]     prod;
	logic [BpW+CntW+RecipW-1:0] quo_full;
	logic [ChW-1:0]          in_ch;
	logic signed [SumW-1:0]  new_sum;

	assign cfg_ready = (state_q == StIdle);
	assign in_ready  = (state_q == StIdle);
	assign in_ch     = ChW'(channel);
	assign bp_sat    = (bp_q > BpFull) ? BpFull : bp_q;
	assign prod      = bp_sat * (n_q - CntW'(1));
	assign quo_full  = prod_q * BpRecip;
	assign new_sum   = sum_q[ch_q] + SumW'(x_q) -
		((n_q == CntW'(Window)) ? SumW'($signed(ring_rd)) : SumW'(0));

	sws_ram #(.Width(DataW), .Depth(Channels * Window)) u_ring (
		.clk(clk), .we(ring_req.we), .waddr(ring_req.waddr), .raddr(ring_req.raddr),
		.wdata(ring_req.wdata), .rdata(ring_rd)
	);

	sws_ram #(.Width(DataW), .Depth(Channels * Window)) u_sort (
		.clk(clk), .we(sort_req.we), .waddr(sort_req.waddr), .raddr(sort_req.raddr),
		.wdata(sort_req.wdata), .rdata(sort_rd)
	);

	sws_div u_div (
		.clk(clk), .arst_n(arst_n), .req(div_req), .done(div_done), .quot(div_q)
	);

	// ram and divider request steering
	always_comb begin
		ring_req       = '0;
		sort_req       = '0;
		div_req        = '0;
		ring_req.raddr = {ch_q, wp_q[ch_q]};
		ring_req.waddr = {ch_q, wp_q[ch_q]};
		sort_req.raddr = {ch_q, i_q[PtrW-1:0]};
		sort_req.waddr = {ch_q, i_q[PtrW-1:0] - PtrW'(1)};
		case (state_q)
			StOldW: begin
				ring_req.we    = 1'b1;
				ring_req.wdata = x_q;
				div_req.start  = 1'b1;
				div_req.dividend = new_sum;
				div_req.divisor  = (n_q == CntW'(Window)) ? n_q : n_q + CntW'(1);
			end
			StRem: begin
				// read entry i+1 and write entry i down to i-1 once old is found
				sort_req.raddr = {ch_q, (i_q[PtrW-1:0] + PtrW'(rd_pend_q))};
				if (found_q && rd_pend_q) begin
					sort_req.we    = 1'b1;
					sort_req.wdata = sort_rd;
				end
			end
			StIns: begin
				if (rd_pend_q) begin
					sort_req.we   = 1'b1;
					if (placed_q) begin
						sort_req.wdata = carry_q;
					end else if (i_q == n_q + CntW'(1) || sort_rd > x_q) begin
						sort_req.wdata = x_q;
					end else begin
						sort_req.wdata = sort_rd;
					end
				end
			end
			StRdMin: sort_req.raddr = {ch_q, PtrW'(0)};
			StRdMax: sort_req.raddr = {ch_q, PtrW'(n_q - CntW'(1))};
			StRdPct, StWait: sort_req.raddr = {ch_q, idx_q};
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= StIdle;
			bp_q      <= BpReset;
			out_valid <= 1'b0;
			div_done_q <= 1'b0;
			rd_pend_q <= 1'b0;
			found_q   <= 1'b0;
			placed_q  <= 1'b0;
			for (int c = 0; c < Channels; c++) begin
				wp_q[c]  <= '0;
				cnt_q[c] <= '0;
				sum_q[c] <= '0;
			end
		end else begin
			if (div_done) begin
				div_done_q <= 1'b1;
			end
			case (state_q)
				StIdle: begin
					if (cfg_valid) begin
						bp_q <= percentile_bp;
					end
					if (in_valid) begin
						ch_q       <= in_ch;
						x_q        <= sample;
						n_q        <= cnt_q[in_ch];
						div_done_q <= 1'b0;
						state_q    <= StOld;
					end
				end
				StOld: state_q <= StOldW;
				StOldW: begin
					old_q        <= ring_rd;
					sum_q[ch_q]  <= new_sum;
					wp_q[ch_q]   <= wp_q[ch_q] + PtrW'(1);
					i_q          <= '0;
					rd_pend_q    <= 1'b0;
					found_q      <= 1'b0;
					placed_q     <= 1'b0;
					state_q      <= (n_q == CntW'(Window)) ? StRem : StIns;
				end
				StRem: begin
					// walk: rd_pend means sort_rd holds entry i
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else begin
						if (!found_q && sort_rd == old_q) begin
							found_q <= 1'b1;
						end
						i_q <= i_q + CntW'(1);
						if (i_q == n_q - CntW'(1)) begin
							n_q       <= n_q - CntW'(1);
							i_q       <= '0;
							rd_pend_q <= 1'b0;
							state_q   <= StIns;
						end
					end
				end
				StIns: begin
					// rewrite entries 0..n with x inserted; entry i-1 is written from its read in the cycle before
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
						i_q       <= i_q + CntW'(1);
					end else begin
						if (placed_q) begin
							carry_q <= sort_rd;
						end else if (i_q == n_q + CntW'(1) || sort_rd > x_q) begin
							placed_q <= 1'b1;
							carry_q  <= sort_rd;
						end
						i_q <= i_q + CntW'(1);
						if (i_q == n_q + CntW'(1)) begin
							n_q          <= n_q + CntW'(1);
							cnt_q[ch_q]  <= n_q + CntW'(1);
							rd_pend_q    <= 1'b0;
							state_q      <= StDiv;
						end
					end
				end
				StDiv: begin
					prod_q  <= prod;
					state_q <= StRdMin;
				end
				StRdMin: begin
					idx_q   <= quo_full[RecipSh +: PtrW];
					state_q <= StRdMax;
				end
				StRdMax: begin
					min_q   <= sort_rd;
					state_q <= StRdPct;
				end
				StRdPct: begin
					max_q   <= sort_rd;
					state_q <= StWait;
				end
				StWait: begin
					percentile_value <= sort_rd;
					if (div_done_q || div_done) begin
						state_q <= StOut;
					end
				end
				StOut: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						count     <= n_q;
						mean      <= div_q;
						minimum   <= min_q;
						maximum   <= max_q;
					end else if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= StIdle;
					end
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	property p_out_only_in_out;
		@(posedge clk) disable iff (!arst_n) out_valid |-> state_q == StOut;
	endproperty
	a_out_only_in_out: assert property (p_out_only_in_out) else $error("stray out_valid");

	property p_count_range;
		@(posedge clk) disable iff (!arst_n) out_valid |-> (count != '0 && count <= CntW'(Window));
	endproperty
	a_count_range: assert property (p_count_range) else $error("count out of range");

	property p_ordered;
		@(posedge clk) disable iff (!arst_n) out_valid |-> (minimum <= percentile_value
			&& percentile_value <= maximum);
	endproperty
	a_ordered: assert property (p_ordered) else $error("order statistics out of order");

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n) (state_q != StIdle) |-> !in_ready;
	endproperty
	a_no_accept_busy: assert property (p_no_accept_busy) else $error("ready while busy");
endmodule

@@ tb/sv/sliding_window_stats_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_stats_core_tb: self-checking bench for the window stats core
// drives channel/sample items with random gaps, predicts count, mean, min,
// max and percentile per channel from a private sorted window, and compares
// every result field by field; percentile_bp is swept across its range
// ----------------------------------------------------------------------------
module sliding_window_stats_core_tb;
	import sws_pkg::*;

	typedef struct packed {
		logic [CntW-1:0]         cnt;
		logic signed [DataW-1:0] avg;
		logic signed [DataW-1:0] lo;
		logic signed [DataW-1:0] hi;
		logic signed [DataW-1:0] pct;
	} stats_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [BpW-1:0]          percentile_bp = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [3:0]              channel = '0;
	logic signed [DataW-1:0] sample = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [CntW-1:0]         count;
	logic signed [DataW-1:0] mean;
	logic signed [DataW-1:0] minimum;
	logic signed [DataW-1:0] maximum;
	logic signed [DataW-1:0] percentile_value;

	sliding_window_stats_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .percentile_bp(percentile_bp),
		.in_valid(in_valid), .in_ready(in_ready), .channel(channel), .sample(sample),
		.out_valid(out_valid), .out_ready(out_ready), .count(count), .mean(mean),
		.minimum(minimum), .maximum(maximum), .percentile_value(percentile_value)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// private copy of the window state
	longint  win_ring [Channels][Window];
	longint  win_sorted [Channels][Window];
	int      win_wp [Channels];
	int      win_fill [Channels];
	longint  win_sum [Channels];
	int      bp_reg = 5000;
	stats_t  pending_stats [$];
	int      errors = 0;
	bit      quiet = 1'b0;
	longint  cycles = 0;

	function automatic stats_t window_update(int ch, longint x);
		stats_t r;
		int n, i, j, bp, idx;
		longint old;
		n = win_fill[ch];
		if (n == Window) begin
			old = win_ring[ch][win_wp[ch]];
			win_sum[ch] -= old;
			i = 0;
			while (win_sorted[ch][i] != old) i++;
			for (j = i; j < n - 1; j++) win_sorted[ch][j] = win_sorted[ch][j+1];
			n--;
		end
		win_ring[ch][win_wp[ch]] = x;
		win_sum[ch] += x;
		i = 0;
		while (i < n && win_sorted[ch][i] <= x) i++;
		for (j = n; j > i; j--) win_sorted[ch][j] = win_sorted[ch][j-1];
		win_sorted[ch][i] = x;
		n++;
		win_fill[ch] = n;
		win_wp[ch] = (win_wp[ch] + 1) % Window;
		bp = (bp_reg > 10000) ? 10000 : bp_reg;
		idx = (bp * (n - 1)) / 10000;
		r.cnt = CntW'(n);
		r.avg = DataW'(win_sum[ch] / n);
		r.lo  = DataW'(win_sorted[ch][0]);
		r.hi  = DataW'(win_sorted[ch][n-1]);
		r.pct = DataW'(win_sorted[ch][idx]);
		return r;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver stall
	always @(negedge clk) begin
		if (!arst_n) out_ready <= 1'b0;
		else out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 17);
	end

	// result checker
	always @(posedge clk) begin
		stats_t e;
		if (out_valid && out_ready) begin
			if (pending_stats.size() == 0) begin
				$display("%0t: unexpected item count=%0d", $realtime, count);
				errors++;
			end else begin
				e = pending_stats[0];
				pending_stats.delete(0);
				if (count !== e.cnt) begin
					$display("%0t: count exp %0d got %0d", $realtime, e.cnt, count);
					errors++;
				end
				if (mean !== e.avg) begin
					$display("%0t: mean exp %0d got %0d", $realtime, e.avg, mean);
					errors++;
				end
				if (minimum !== e.lo) begin
					$display("%0t: minimum exp %0d got %0d", $realtime, e.lo, minimum);
					errors++;
				end
				if (maximum !== e.hi) begin
					$display("%0t: maximum exp %0d got %0d", $realtime, e.hi, maximum);
					errors++;
				end
				if (percentile_value !== e.pct) begin
					$display("%0t: percentile exp %0d got %0d", $realtime, e.pct,
						percentile_value);
					errors++;
				end
			end
		end
	end

	task automatic send_item(int ch, logic signed [DataW-1:0] x);
		stats_t s;
		while (!quiet && $urandom_range(0, 99) < 17) @(negedge clk);
		in_valid <= 1'b1;
		channel  <= ch[3:0];
		sample   <= x;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		s = window_update(ch % Channels, longint'(x));
		pending_stats = {pending_stats, s};
		@(negedge clk);
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_bp(int v);
		drain();
		cfg_valid     <= 1'b1;
		percentile_bp <= v[BpW-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		bp_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [DataW-1:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return $signed(32'($urandom_range(0, 20))) - 10;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_item(0, 32'sh7fffffff);
		send_item(0, 32'sh80000000);
		send_item(0, 0);
		send_item(0, 32'sh00010000);
		send_item(15, -1);
		send_item(15, -1);
		send_item(15, 5);
		send_item(1, 32'sh55555555);
		send_item(2, 32'shaaaaaaaa);
		write_bp(0);
		send_item(0, 7);
		write_bp(10000);
		send_item(0, 8);
		write_bp(16383);
		send_item(15, 9);
		write_bp(5000);
	endtask

	// fill one channel past its window with repeated values to exercise eviction
	task automatic test_eviction();
		for (int i = 0; i < 300; i++)
			send_item(3, (i % 7 == 0) ? 32'sh7fffffff : $signed(32'(i % 5)) - 2);
	endtask

	task automatic test_random(int n);
		int ch;
		for (int i = 0; i < n; i++) begin
			ch = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(4, 5);
			send_item(ch, rand_sample());
		end
	endtask

	task automatic test_bp_sweep();
		int vals[5] = '{0, 1, 2500, 9999, 12000};
		foreach (vals[k]) begin
			write_bp(vals[k]);
			test_random(60);
		end
	endtask

	initial begin
		for (int c = 0; c < Channels; c++) begin
			win_wp[c] = 0;
			win_fill[c] = 0;
			win_sum[c] = 0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_eviction();
		test_random(300);
		test_bp_sweep();
		quiet = 1'b1;
		test_random(150);
		quiet = 1'b0;
		write_bp($urandom_range(0, 10000));
		test_random(90);
		drain();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
